>>> rtl/tss_pkg.sv
// Shared types for the two-stack sorter: request and result payload structs
// and the data width. No dependencies.
`default_nettype none
package tss_pkg;

  localparam int unsigned DATA_W = 32;

  // one request: a value to stack, with the end-of-run mark
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } item_t;

  // one result: a sorted value, with the end-of-run mark
  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     final_res;
  } result_t;

endpackage
`default_nettype wire

>>> rtl/tss_stack_mem.sv
// Stack storage for the two-stack sorter: one write port and one read port,
// read data registered. Depends on tss_pkg.
`default_nettype none
module tss_stack_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [AW-1:0]             waddr,
  input  wire logic [tss_pkg::DATA_W-1:0] wdata,
  input  wire logic                      re,
  input  wire logic [AW-1:0]             raddr,
  output logic      [tss_pkg::DATA_W-1:0] rdata
);
  import tss_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  // write entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read entry, hold data when idle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/two_stack_sorter_top.sv
// Two-stack sorter top level: request/result handshakes, stack sequencer and
// the two stack memories. Depends on tss_pkg and tss_stack_mem.
//
//   port group           dir  payload    notes
//   item_valid/ready     in   item_t     value and last mark
//   res_valid/ready      out  result_t   ascending values, final_res on last
//
// Loading accepts one request per cycle. On the request marked last the
// sequencer sorts: it pops each source entry into a register, moves each
// greater auxiliary top back onto the source stack, then pushes the popped
// entry onto the auxiliary stack; each stack memory has one read port. Each
// result is read from the auxiliary stack, then presented. rst is synchronous
// and clears the sequencer and both counts; memory contents are not cleared.
// A stalled result holds the sequencer; no request is taken until the run ends.
`default_nettype none
module two_stack_sorter_top #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_ready,
  input  wire tss_pkg::item_t   item,
  output logic                  res_valid,
  input  wire logic             res_ready,
  output tss_pkg::result_t      res
);
  import tss_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_POP  = 3'd1;
  localparam logic [2:0] ST_LOAD = 3'd2;
  localparam logic [2:0] ST_CMP  = 3'd3;
  localparam logic [2:0] ST_RD   = 3'd4;
  localparam logic [2:0] ST_SHOW = 3'd5;

  logic [2:0]        state;
  logic [CW-1:0]     src_cnt;
  logic [CW-1:0]     aux_cnt;
  logic [CW-1:0]     out_idx;
  logic [DATA_W-1:0] tmp;

  logic [CW-1:0]     src_top;
  logic [CW-1:0]     aux_top;
  logic [CW-1:0]     aux_below;
  logic [CW-1:0]     out_idx_inc;
  logic              move_back;

  logic              src_we, src_re, aux_we, aux_re;
  logic [AW-1:0]     src_waddr, src_raddr, aux_waddr, aux_raddr;
  logic [DATA_W-1:0] src_wdata, aux_wdata, src_q, aux_q;

  assign src_top     = src_cnt - CW'(1);
  assign aux_top     = aux_cnt - CW'(1);
  assign aux_below   = aux_cnt - CW'(2);
  assign out_idx_inc = out_idx + CW'(1);

  // auxiliary top is strictly greater than the popped value
  assign move_back = (aux_cnt != '0) && ($signed(aux_q) > $signed(tmp));

  assign item_ready       = (state == ST_IDLE);
  assign res_valid        = (state == ST_SHOW);
  assign res.sorted_value = $signed(aux_q);
  assign res.final_res    = (out_idx_inc == aux_cnt);

  // drive memory ports per state
  always_comb begin
    src_we    = 1'b0;
    src_waddr = src_cnt[AW-1:0];
    src_wdata = item.value;
    src_re    = 1'b0;
    src_raddr = src_top[AW-1:0];
    aux_we    = 1'b0;
    aux_waddr = aux_cnt[AW-1:0];
    aux_wdata = tmp;
    aux_re    = 1'b0;
    aux_raddr = aux_top[AW-1:0];
    case (state)
      ST_IDLE: begin
        src_we = item_valid && (src_cnt < CW'(DEPTH));
      end
      ST_POP: begin
        src_re = (src_cnt != '0);
        aux_re = (src_cnt != '0);
      end
      ST_CMP: begin
        if (move_back) begin
          src_we    = 1'b1;
          src_wdata = aux_q;
          aux_re    = 1'b1;
          aux_raddr = aux_below[AW-1:0];
        end else begin
          aux_we = 1'b1;
        end
      end
      ST_RD: begin
        aux_re    = 1'b1;
        aux_raddr = out_idx[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  // advance the sequencer and the stack counts
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      src_cnt <= '0;
      aux_cnt <= '0;
      out_idx <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (item_valid) begin
            if (src_cnt < CW'(DEPTH)) begin
              src_cnt <= src_cnt + CW'(1);
            end
            if (item.last) begin
              aux_cnt <= '0;
              state   <= ST_POP;
            end
          end
        end
        ST_POP: begin
          if (src_cnt == '0) begin
            out_idx <= '0;
            state   <= ST_RD;
          end else begin
            src_cnt <= src_top;
            state   <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          state <= ST_CMP;
        end
        ST_CMP: begin
          if (move_back) begin
            src_cnt <= src_cnt + CW'(1);
            aux_cnt <= aux_top;
          end else begin
            aux_cnt <= aux_cnt + CW'(1);
            state   <= ST_POP;
          end
        end
        ST_RD: begin
          state <= ST_SHOW;
        end
        ST_SHOW: begin
          if (res_ready) begin
            if (res.final_res) begin
              src_cnt <= '0;
              aux_cnt <= '0;
              state   <= ST_IDLE;
            end else begin
              out_idx <= out_idx_inc;
              state   <= ST_RD;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // hold the popped value
  always_ff @(posedge clk) begin
    if (state == ST_LOAD) begin
      tmp <= src_q;
    end
  end

  tss_stack_mem #(.DEPTH(DEPTH), .AW(AW)) u_src_mem (
    .clk   (clk),
    .we    (src_we),
    .waddr (src_waddr),
    .wdata (src_wdata),
    .re    (src_re),
    .raddr (src_raddr),
    .rdata (src_q)
  );

  tss_stack_mem #(.DEPTH(DEPTH), .AW(AW)) u_aux_mem (
    .clk   (clk),
    .we    (aux_we),
    .waddr (aux_waddr),
    .wdata (aux_wdata),
    .re    (aux_re),
    .raddr (aux_raddr),
    .rdata (aux_q)
  );

`ifndef ASSERT_OFF
  // requests and results never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(item_ready && res_valid))
    else $error("request and result channels active together");

  // entries in both stacks together never exceed the depth
  a_conserve: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, src_cnt} + {1'b0, aux_cnt}) <= (CW + 1)'(DEPTH))
    else $error("stack entries exceed depth");

  // the final result returns the block to loading
  a_final_idle: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_ready && res.final_res) |=> (item_ready && src_cnt == '0))
    else $error("block not empty after final result");

  // results only come from a nonempty auxiliary stack
  a_res_src: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (out_idx < aux_cnt))
    else $error("result index beyond auxiliary stack");
`endif

endmodule
`default_nettype wire
